/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSC_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define BSC_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

/* hdl/bsc_pkg.sv */
package bsc_pkg;

	localparam int DW       = 64;
	localparam int MUL_LAT  = 2;
	localparam int DIV_LAT  = DW + 2;
	localparam int FRONT_LAT = 12;
	localparam int BACK_LAT  = 8;
	localparam int LAT      = FRONT_LAT + DIV_LAT + BACK_LAT;

	localparam int C_FINE_OFS = 128000;
	localparam int C_P_BASE   = 1048576;
	localparam int C_P_SCALE  = 3125;
	localparam int SH_P4      = 35;
	localparam int SH_P5      = 17;
	localparam int SH_ONE     = 47;

	typedef enum logic [2:0] {
		REG_TEMP_CAL   = 3'd0,
		REG_PRESS_LO   = 3'd1,
		REG_PRESS_HI   = 3'd2,
		REG_PRESS_LAST = 3'd3
	} reg_idx_t;

endpackage

/* hdl/bsc_delay.sv */
module bsc_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_q [0:N-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign q = dly_q[N-1];

endmodule

/* hdl/bsc_mul.sv */
// x times y modulo 2^64, two stages
module bsc_mul import bsc_pkg::*; #(
	parameter int YW = 17
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DW-1:0]        x,
	input  logic signed [YW-1:0] y,
	output logic [DW-1:0]        p
);

	localparam int HW = DW / 2;
	localparam int LW = HW + 1 + YW;

	logic signed [LW-1:0] lo_s1;
	logic [HW-1:0]        hi_s1;
	logic [HW-1:0]        ysx;
	logic [DW-1:0]        p_s2;

	assign ysx = {{(HW-YW){y[YW-1]}}, y};

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= $signed({1'b0, x[HW-1:0]}) * y;
			hi_s1 <= x[DW-1:HW] * ysx;
			p_s2  <= {{(DW-LW){lo_s1[LW-1]}}, lo_s1} + {hi_s1, {HW{1'b0}}};
		end
	end

	assign p = p_s2;

endmodule

/* hdl/bsc_div.sv */
// signed truncating divider, one quotient bit per stage
module bsc_div import bsc_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] quo,
	output logic          dz
);

	logic [DW-1:0] rem_q [0:DW];
	logic [DW-1:0] quo_q [0:DW];
	logic [DW-1:0] den_q [0:DW];
	logic          neg_q [0:DW];
	logic          dz_q  [0:DW];
	logic [DW-1:0] res_q;
	logic          dzo_q;

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q[0] <= num[DW-1] ? (~num + 1'b1) : num;
			den_q[0] <= den[DW-1] ? (~den + 1'b1) : den;
			rem_q[0] <= '0;
			neg_q[0] <= num[DW-1] ^ den[DW-1];
			dz_q[0]  <= (den == '0);
		end
	end

	for (genvar g = 1; g <= DW; g++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		assign trial = {rem_q[g-1], quo_q[g-1][DW-1]};
		assign diff  = trial - {1'b0, den_q[g-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
				quo_q[g] <= {quo_q[g-1][DW-2:0], ~diff[DW]};
				den_q[g] <= den_q[g-1];
				neg_q[g] <= neg_q[g-1];
				dz_q[g]  <= dz_q[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= neg_q[DW] ? (~quo_q[DW] + 1'b1) : quo_q[DW];
			dzo_q <= dz_q[DW];
		end
	end

	assign quo = res_q;
	assign dz  = dzo_q;

endmodule

/* hdl/barometer_sample_compensation.sv */
// barometer sample compensation
// input channel: in_valid/in_stall with raw_temperature and raw_pressure,
// one request per sample pair. output channel: out_valid/out_stall with
// temperature_centi, pressure_q24_8 and divide_fault, one result per request.
// calibration is loaded through wr_en/wr_index/wr_data; the user must do so
// only while no request is in flight; the block does not enforce this. index
// 0 temperature set, 1 and 2 pressure sets, 3 last term. results pass the
// 66-stage divider and the multiply stages around it; one request per cycle
// is taken unless out_stall holds it: when out_stall is high with a result
// waiting, the whole pipeline holds and in_stall rises in the same cycle;
// nothing is dropped or repeated. reset clears the calibration registers
// and all valid bits; the pipeline comes out of reset empty and ready.
module barometer_sample_compensation import bsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [63:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic               divide_fault
);

	`include "assert_macros.svh"

	logic [47:0] temp_cal_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [15:0] press_last_q;
	logic        en;
	logic [LAT:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q   <= '0;
			press_lo_q   <= '0;
			press_hi_q   <= '0;
			press_last_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TEMP_CAL:   temp_cal_q   <= wr_data[47:0];
				REG_PRESS_LO:   press_lo_q   <= wr_data;
				REG_PRESS_HI:   press_hi_q   <= wr_data;
				REG_PRESS_LAST: press_last_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_cal_q[15:0];
	assign t2 = temp_cal_q[31:16];
	assign t3 = temp_cal_q[47:32];
	assign p1 = press_lo_q[15:0];
	assign p2 = press_lo_q[31:16];
	assign p3 = press_lo_q[47:32];
	assign p4 = press_lo_q[63:48];
	assign p5 = press_hi_q[15:0];
	assign p6 = press_hi_q[31:16];
	assign p7 = press_hi_q[47:32];
	assign p8 = press_hi_q[63:48];
	assign p9 = press_last_q;

	// handshake and valid pipe
	assign en        = ~(vld_q[LAT] & out_stall);
	assign in_stall  = ~en;
	assign out_valid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], in_valid};
		end
	end

	// fine temperature
	logic signed [17:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic signed [33:0] m1_s2, sq_s2;
	logic signed [22:0] x1_s3;
	logic signed [37:0] m3_s3;
	logic signed [25:0] fine_s4;
	logic signed [28:0] tscaled;
	logic signed [20:0] tshift;
	logic signed [15:0] tc_s5;
	logic signed [26:0] a_s5;

	assign tscaled = 29'(fine_s4) * 29'sd5 + 29'sd128;
	assign tshift  = tscaled[28:8];

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1   <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
			d2_s1   <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
			m1_s2   <= d1_s1 * t2;
			sq_s2   <= d2_s1 * d2_s1;
			x1_s3   <= m1_s2[33:11];
			m3_s3   <= $signed(sq_s2[33:12]) * t3;
			fine_s4 <= 26'(x1_s3) + 26'($signed(m3_s3[37:14]));
			if (tshift > 21'sd32767) begin
				tc_s5 <= 16'sh7fff;
			end else if (tshift < -21'sd32768) begin
				tc_s5 <= 16'sh8000;
			end else begin
				tc_s5 <= tshift[15:0];
			end
			a_s5 <= 27'(fine_s4) - 27'(C_FINE_OFS);
		end
	end

	// pressure numerator and divisor
	logic signed [53:0] aa_s6;
	logic signed [42:0] ap5_s6, ap2_s6, ap2_s7;
	logic signed [69:0] aap6, aap3;
	logic [63:0]        bt_s7, aap3_s7, bpart_s7;
	logic [63:0]        b_s8, a2_s8, v_s9, nb_s9;
	logic [19:0]        adcp_s8;
	logic [20:0]        pd;
	logic [63:0]        pv_s11, pn_s11;
	logic [63:0]        a3_s12, num_s12;

	assign aap6 = aa_s6 * p6;
	assign aap3 = aa_s6 * p3;
	assign pd   = 21'(C_P_BASE) - {1'b0, adcp_s8};

	bsc_delay #(.W(20), .N(8)) u_adcp_dly (
		.clk(clk), .en(en), .d(raw_pressure), .q(adcp_s8)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s6    <= a_s5 * a_s5;
			ap5_s6   <= a_s5 * p5;
			ap2_s6   <= a_s5 * p2;
			bt_s7    <= aap6[63:0];
			aap3_s7  <= aap3[63:0];
			bpart_s7 <= ({{21{ap5_s6[42]}}, ap5_s6} << SH_P5)
				+ ({{48{p4[15]}}, p4} << SH_P4);
			ap2_s7   <= ap2_s6;
			b_s8     <= bt_s7 + bpart_s7;
			a2_s8    <= {{8{aap3_s7[63]}}, aap3_s7[63:8]}
				+ ({{21{ap2_s7[42]}}, ap2_s7} << 12);
			v_s9     <= (64'd1 << SH_ONE) + a2_s8;
			nb_s9    <= ({43'd0, pd} << 31) - b_s8;
			a3_s12   <= {{33{pv_s11[63]}}, pv_s11[63:33]};
			num_s12  <= pn_s11;
		end
	end

	bsc_mul #(.YW(17)) u_mul_p1 (
		.clk(clk), .en(en), .x(v_s9), .y($signed({1'b0, p1})), .p(pv_s11)
	);

	bsc_mul #(.YW(17)) u_mul_scale (
		.clk(clk), .en(en), .x(nb_s9), .y(17'(C_P_SCALE)), .p(pn_s11)
	);

	logic [63:0] q_s78;
	logic        dz_s78;

	bsc_div u_div (
		.clk(clk), .en(en), .num(num_s12), .den(a3_s12), .quo(q_s78), .dz(dz_s78)
	);

	// final correction
	logic [63:0] sa_s79, sqlo_s80, ss_s81;
	logic [31:0] cross_s80;
	logic [63:0] md_s80, md_s83, mc_s83, p_s83;
	logic [63:0] sum_s84, res_s85;
	logic        dz_s85;
	logic signed [15:0] tc_s85;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s79    <= {{13{q_s78[63]}}, q_s78[63:13]};
			sqlo_s80  <= sa_s79[31:0] * sa_s79[31:0];
			cross_s80 <= sa_s79[31:0] * sa_s79[63:32];
			ss_s81    <= sqlo_s80 + {cross_s80[30:0], 1'b0, 32'd0};
			sum_s84   <= p_s83 + {{25{mc_s83[63]}}, mc_s83[63:25]}
				+ {{19{md_s83[63]}}, md_s83[63:19]};
			res_s85   <= {{8{sum_s84[63]}}, sum_s84[63:8]} + ({{48{p7[15]}}, p7} << 4);
		end
	end

	bsc_mul #(.YW(17)) u_mul_p8 (
		.clk(clk), .en(en), .x(q_s78), .y($signed({p8[15], p8})), .p(md_s80)
	);

	bsc_mul #(.YW(17)) u_mul_p9 (
		.clk(clk), .en(en), .x(ss_s81), .y($signed({p9[15], p9})), .p(mc_s83)
	);

	bsc_delay #(.W(64), .N(3)) u_md_dly (
		.clk(clk), .en(en), .d(md_s80), .q(md_s83)
	);

	bsc_delay #(.W(64), .N(5)) u_p_dly (
		.clk(clk), .en(en), .d(q_s78), .q(p_s83)
	);

	bsc_delay #(.W(1), .N(LAT - 1 - FRONT_LAT - DIV_LAT)) u_dz_dly (
		.clk(clk), .en(en), .d(dz_s78), .q(dz_s85)
	);

	bsc_delay #(.W(16), .N(LAT - 1 - 5)) u_tc_dly (
		.clk(clk), .en(en), .d(tc_s5), .q(tc_s85)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			temperature_centi <= tc_s85;
			divide_fault      <= dz_s85;
			if (dz_s85 || res_s85[63]) begin
				pressure_q24_8 <= '0;
			end else if (|res_s85[62:32]) begin
				pressure_q24_8 <= '1;
			end else begin
				pressure_q24_8 <= res_s85[31:0];
			end
		end
	end

	`BSC_ASSERT_IMP(a_fault_zero, clk, arst_n, out_valid && divide_fault, pressure_q24_8 == '0)
	`BSC_ASSERT_NXT(a_req_enters, clk, arst_n, in_valid && !in_stall, vld_q[1])
	`BSC_ASSERT_NXT(a_hold_pipe, clk, arst_n, !en, $stable(vld_q))

endmodule
